FILE: rtl/rde_pkg.sv
// Shared types and constants for the radix digit extractor.
// No dependencies; imported by every module of the block.
package rde_pkg;

  // Default sizing
  localparam int MAX_SLOTS_DEF  = 8;
  localparam int VALUE_BITS_DEF = 32;

  // Register reset values
  localparam logic [3:0]  MAX_DIGITS_RST = 4'd4;
  localparam logic [4:0]  RADIX_RST      = 5'd10;
  localparam logic        LEAD_ZEROS_RST = 1'b0;
  localparam logic [15:0] POS_X_RST      = 16'd0;
  localparam logic [15:0] PITCH_RST      = 16'd0;

  // Radix limits and x position ceiling
  localparam logic [4:0]  RADIX_MIN = 5'd2;
  localparam logic [4:0]  RADIX_MAX = 5'd16;
  localparam logic [15:0] X_MAX     = 16'hFFFF;

  // Register map
  typedef enum logic [2:0] {
    REG_MAX_DIGITS = 3'd0,
    REG_RADIX      = 3'd1,
    REG_LEAD_ZEROS = 3'd2,
    REG_POS_X      = 3'd3,
    REG_PITCH      = 3'd4
  } rde_reg_t;

  typedef struct packed {
    logic [3:0]  max_digits;
    logic [4:0]  radix;
    logic        lead_zeros;
    logic [15:0] pos_x;
    logic [15:0] digit_pitch;
  } rde_cfg_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_STORE,
    ST_EMIT
  } rde_state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;         // take a new item
    logic div_step;     // one bit of the division
    logic digit_store;  // write remainder, move to next slot
    logic emit_init;    // start emitting from the top slot
    logic emit_load;    // fill the output register
  } rde_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic q_zero;
    logic s_zero;
    logic bit_last;
    logic emit_empty;
    logic emit_last;
    logic out_free;
  } rde_status_t;

endpackage

FILE: rtl/rde_datapath.sv
// Datapath: bit-serial divider, digit store, emit counter and output register.
// Depends on rde_pkg.
module rde_datapath import rde_pkg::*; #(
  parameter int MAX_SLOTS  = MAX_SLOTS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  rde_cfg_t              cfg,
  input  rde_cmd_t              cmd,
  output rde_status_t           status,
  input  logic [VALUE_BITS-1:0] number_in,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [3:0]            digit,
  output logic [2:0]            slot,
  output logic [15:0]           x_pos,
  output logic                  overflow,
  output logic                  last
);

  localparam int CNT_W = $clog2(MAX_SLOTS + 1);
  localparam int IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int BIT_W = $clog2(VALUE_BITS);
  localparam int PRD_W = CNT_W + 16;

  // Working registers
  logic [VALUE_BITS-1:0] q;
  logic [3:0]            rem;
  logic [BIT_W-1:0]      bit_cnt;
  logic [CNT_W-1:0]      s;
  logic [CNT_W-1:0]      e;
  logic [3:0]            digits [MAX_SLOTS];

  // Clamped configuration
  logic [4:0]       md_ext;
  logic [4:0]       slots_w;
  logic [CNT_W-1:0] slots;
  logic [4:0]       base;

  always_comb begin
    md_ext  = {1'b0, cfg.max_digits};
    slots_w = 5'd1;
    if (md_ext > 5'(MAX_SLOTS)) begin
      slots_w = 5'(MAX_SLOTS);
    end else if (md_ext != 5'd0) begin
      slots_w = md_ext;
    end
    slots = CNT_W'(slots_w);
    if (cfg.radix < RADIX_MIN) begin
      base = RADIX_MIN;
    end else if (cfg.radix > RADIX_MAX) begin
      base = RADIX_MAX;
    end else begin
      base = cfg.radix;
    end
  end

  // Restoring division step: remainder stays below base
  logic [4:0] rem_sh;
  logic       ge;
  assign rem_sh = {rem, q[VALUE_BITS-1]};
  assign ge     = (rem_sh >= base);

  logic [CNT_W-1:0] s_m1;
  assign s_m1 = s - 1'b1;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      q       <= number_in;
      rem     <= '0;
      bit_cnt <= '0;
      s       <= slots;
    end else if (cmd.div_step) begin
      q       <= {q[VALUE_BITS-2:0], ge};
      rem     <= ge ? 4'(rem_sh - base) : rem_sh[3:0];
      bit_cnt <= bit_cnt + 1'b1;
    end else if (cmd.digit_store) begin
      digits[s_m1[IDX_W-1:0]] <= rem;
      rem     <= '0;
      bit_cnt <= '0;
      s       <= s_m1;
    end
  end

  // Emit side
  logic [CNT_W-1:0] end_slot;
  logic [CNT_W-1:0] e_m1;
  assign end_slot = cfg.lead_zeros ? '0 : s;
  assign e_m1     = e - 1'b1;

  always_ff @(posedge clk) begin
    if (cmd.emit_init) begin
      e <= slots;
    end else if (cmd.emit_load) begin
      e <= e_m1;
    end
  end

  // Slot x position with saturation
  logic [PRD_W-1:0] prod;
  logic [PRD_W:0]   xsum;
  logic [15:0]      x_sat;
  always_comb begin
    prod  = PRD_W'(e_m1) * PRD_W'(cfg.digit_pitch);
    xsum  = {1'b0, prod} + (PRD_W + 1)'(cfg.pos_x);
    x_sat = (xsum > (PRD_W + 1)'(X_MAX)) ? X_MAX : xsum[15:0];
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      digit    <= (e_m1 >= s) ? digits[e_m1[IDX_W-1:0]] : 4'd0;
      slot     <= 3'(e_m1);
      x_pos    <= x_sat;
      overflow <= (q != '0);
      last     <= (e_m1 == end_slot);
    end
  end

  // Status back to the controller
  always_comb begin
    status.q_zero     = (q == '0);
    status.s_zero     = (s == '0);
    status.bit_last   = (bit_cnt == BIT_W'(VALUE_BITS - 1));
    status.emit_empty = (e == end_slot);
    status.emit_last  = (e_m1 == end_slot);
    status.out_free   = !out_valid || out_ready;
  end

endmodule

FILE: rtl/rde_ctrl.sv
// Controller state machine sequencing division, digit store and emission.
// Depends on rde_pkg.
module rde_ctrl import rde_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  rde_status_t status,
  output rde_cmd_t    cmd
);

  rde_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_CHECK;
        end
      end
      // Stop dividing once the value is used up or the slots run out
      ST_CHECK: begin
        if (status.q_zero || status.s_zero) begin
          cmd.emit_init = 1'b1;
          state_next    = ST_EMIT;
        end else begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.bit_last) begin
          state_next = ST_STORE;
        end
      end
      ST_STORE: begin
        cmd.digit_store = 1'b1;
        state_next      = ST_CHECK;
      end
      // One item per cycle while the output register is free
      ST_EMIT: begin
        if (status.emit_empty) begin
          state_next = ST_IDLE;
        end else if (status.out_free) begin
          cmd.emit_load = 1'b1;
          if (status.emit_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/radix_digit_extractor.sv
// Radix digit extractor: splits an unsigned value into digits of a configured
// base, least significant first, one item per digit from slot max_digits-1
// down, with max_digits clamped to 1..MAX_SLOTS. A shared bit-serial divider
// produces one quotient bit per cycle; each digit takes a check, a division
// and a store. The input is not taken again until the last result of a
// value is loaded into the output register, so output stalls hold it off.
// All results of a value carry the overflow flag, so emission starts only
// after the last division. The final result sits in the output register
// while the next value is taken in. Configuration registers are written
// through cfg_valid/cfg_ready at any time, but should change only while no
// item is in flight. Depends on rde_pkg, rde_ctrl and rde_datapath.
module radix_digit_extractor import rde_pkg::*; #(
  parameter int MAX_SLOTS  = MAX_SLOTS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // Configuration write channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [2:0]            cfg_index,
  input  logic [15:0]           cfg_data,
  // Input channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [VALUE_BITS-1:0] number_in,
  // Output channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [3:0]            digit,
  output logic [2:0]            slot,
  output logic [15:0]           x_pos,
  output logic                  overflow,
  output logic                  last
);

  rde_cfg_t    cfg;
  rde_cmd_t    cmd;
  rde_status_t status;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_digits  <= MAX_DIGITS_RST;
      cfg.radix       <= RADIX_RST;
      cfg.lead_zeros  <= LEAD_ZEROS_RST;
      cfg.pos_x       <= POS_X_RST;
      cfg.digit_pitch <= PITCH_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MAX_DIGITS: cfg.max_digits  <= cfg_data[3:0];
        REG_RADIX:      cfg.radix       <= cfg_data[4:0];
        REG_LEAD_ZEROS: cfg.lead_zeros  <= cfg_data[0];
        REG_POS_X:      cfg.pos_x       <= cfg_data;
        REG_PITCH:      cfg.digit_pitch <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  rde_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  rde_datapath #(
    .MAX_SLOTS  (MAX_SLOTS),
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd       (cmd),
    .status    (status),
    .number_in (number_in),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .digit     (digit),
    .slot      (slot),
    .x_pos     (x_pos),
    .overflow  (overflow),
    .last      (last)
  );

endmodule
